>>> hdl/crfr_pkg.sv
// ----------------------------------------------------------------------------
// crfr_pkg
// Shared widths, codes and control types of the CAN receive frame router.
// ----------------------------------------------------------------------------
package crfr_pkg;

	localparam int ID_W       = 11;
	localparam int SLOT_W     = 3;
	localparam int MODE_W     = 3;
	localparam int DLC_W      = 4;
	localparam int DATA_W     = 64;
	localparam int MASK_W     = 8;
	localparam int LEN_W      = 4;
	localparam int DISP_W     = 3;
	localparam int FRAMES_W   = 32;
	localparam int DISTINCT_W = 6;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 5;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 3;
	localparam int OUT_PAD_W  = OUT_DATA_W - MASK_W - LEN_W - DATA_W - FRAMES_W - DISTINCT_W;

	localparam logic [DLC_W-1:0] MAX_DATA_BYTES = 4'd8;

	localparam int DEF_LISTENER_SLOTS = 8;
	localparam int DEF_IDS_PER_SLOT   = 16;
	localparam int DEF_DIAG_ID_DEPTH  = 32;

	localparam logic [MODE_W-1:0] MODE_FRAME   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

	localparam logic [DISP_W-1:0] DISP_DROPPED   = 3'd0;
	localparam logic [DISP_W-1:0] DISP_DIAG      = 3'd1;
	localparam logic [DISP_W-1:0] DISP_LISTENERS = 3'd2;
	localparam logic [DISP_W-1:0] DISP_QUEUE     = 3'd3;
	localparam logic [DISP_W-1:0] DISP_DONE      = 3'd4;
	localparam logic [DISP_W-1:0] DISP_REJECT    = 3'd5;

	typedef struct packed {
		logic              op_set;
		logic              op_append;
		logic              op_disable;
		logic              start;
		logic              cmp_en;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   lo;
		logic [ID_W-1:0]   hi;
	} cell_ctl_t;

endpackage

>>> hdl/crfr_ram.sv
// ----------------------------------------------------------------------------
// crfr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module crfr_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/crfr_cell.sv
// ----------------------------------------------------------------------------
// crfr_cell
// One listener slot: range, enable, ID list, and one link of the match chain.
// ----------------------------------------------------------------------------
module crfr_cell import crfr_pkg::*; #(
	parameter int IDX          = 0,
	parameter int IDS_PER_SLOT = DEF_IDS_PER_SLOT,
	localparam int AW = (IDS_PER_SLOT > 1) ? $clog2(IDS_PER_SLOT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [MASK_W-1:0] mask_in,
	input  logic              any_in,
	output logic [MASK_W-1:0] mask_out,
	output logic              any_out,
	output logic              append_ok
);

	localparam int CW    = $clog2(IDS_PER_SLOT + 1);
	localparam int CMP_W = AW + CW;

	logic              en_q;
	logic [ID_W-1:0]   lo_q;
	logic [ID_W-1:0]   hi_q;
	logic [CW-1:0]     cnt_q;
	logic              rng_ok_q;
	logic              empty_q;
	logic              hit_q;
	logic [AW-1:0]     rd_addr_s1;
	logic [MASK_W-1:0] mask_q;
	logic              any_q;

	logic              sel;
	logic              not_full;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [ID_W-1:0]   ram_rdata;
	logic              match;
	logic [MASK_W-1:0] own_mask;

	assign sel       = (32'(ctl.slot) == IDX);
	assign not_full  = (cnt_q < CW'(IDS_PER_SLOT));
	assign append_ok = sel && en_q && not_full;
	assign ram_we    = ctl.op_append && append_ok;
	assign ram_addr  = ram_we ? cnt_q[AW-1:0] : rd_addr;
	assign match     = rng_ok_q && (empty_q || hit_q);
	assign own_mask  = (IDX < MASK_W) ? (MASK_W'(1) << IDX) : '0;

	crfr_ram #(
		.WIDTH (ID_W),
		.DEPTH (IDS_PER_SLOT)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ctl.id),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			cnt_q      <= '0;
			rng_ok_q   <= 1'b0;
			empty_q    <= 1'b0;
			hit_q      <= 1'b0;
			rd_addr_s1 <= '0;
			mask_q     <= '0;
			any_q      <= 1'b0;
		end else begin
			rd_addr_s1 <= rd_addr;
			mask_q     <= mask_in | (match ? own_mask : '0);
			any_q      <= any_in | match;
			if (ctl.op_set && sel) begin
				en_q  <= 1'b1;
				lo_q  <= ctl.lo;
				hi_q  <= ctl.hi;
				cnt_q <= '0;
			end
			if (ctl.op_disable && sel) begin
				en_q  <= 1'b0;
				cnt_q <= '0;
			end
			if (ram_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (ctl.start) begin
				rng_ok_q <= en_q && (ctl.id >= lo_q) && (ctl.id <= hi_q);
				empty_q  <= (cnt_q == '0);
				hit_q    <= 1'b0;
			end else if (ctl.cmp_en && (CMP_W'(rd_addr_s1) < CMP_W'(cnt_q))
					&& (ram_rdata == ctl.id)) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign mask_out = mask_q;
	assign any_out  = any_q;

endmodule

>>> hdl/crfr_diag.sv
// ----------------------------------------------------------------------------
// crfr_diag
// Diagnostic tap: frame counter and bounded store of distinct IDs.
// ----------------------------------------------------------------------------
module crfr_diag import crfr_pkg::*; #(
	parameter int DIAG_ID_DEPTH = DEF_DIAG_ID_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  start,
	input  logic [ID_W-1:0]       id,
	output logic                  done,
	output logic [FRAMES_W-1:0]   frames,
	output logic [DISTINCT_W-1:0] distinct
);

	localparam int AW    = (DIAG_ID_DEPTH > 1) ? $clog2(DIAG_ID_DEPTH) : 1;
	localparam int CW    = $clog2(DIAG_ID_DEPTH + 1);
	localparam int CMP_W = AW + CW;

	typedef enum logic [1:0] {
		D_IDLE,
		D_WALK,
		D_DRAIN,
		D_UPDATE
	} dstate_t;

	dstate_t             state_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       walk_q;
	logic [AW-1:0]       rd_addr_s1;
	logic                rd_en_s1;
	logic                found_q;
	logic [ID_W-1:0]     id_q;
	logic                done_q;

	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [ID_W-1:0]     ram_rdata;

	assign ram_we   = (state_q == D_UPDATE) && !found_q && (count_q < CW'(DIAG_ID_DEPTH));
	assign ram_addr = ram_we ? count_q[AW-1:0] : walk_q;

	crfr_ram #(
		.WIDTH (ID_W),
		.DEPTH (DIAG_ID_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (id_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= D_IDLE;
			frames_q   <= '0;
			count_q    <= '0;
			walk_q     <= '0;
			rd_addr_s1 <= '0;
			rd_en_s1   <= 1'b0;
			found_q    <= 1'b0;
			id_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			rd_addr_s1 <= walk_q;
			rd_en_s1   <= (state_q == D_WALK);
			done_q     <= 1'b0;
			if (rd_en_s1 && (CMP_W'(rd_addr_s1) < CMP_W'(count_q)) && (ram_rdata == id_q)) begin
				found_q <= 1'b1;
			end
			case (state_q)
				D_IDLE: begin
					if (clear) begin
						frames_q <= '0;
						count_q  <= '0;
					end else if (start) begin
						frames_q <= frames_q + FRAMES_W'(1);
						id_q     <= id;
						found_q  <= 1'b0;
						walk_q   <= '0;
						state_q  <= D_WALK;
					end
				end
				D_WALK: begin
					if (walk_q == AW'(DIAG_ID_DEPTH - 1)) begin
						state_q <= D_DRAIN;
					end else begin
						walk_q <= walk_q + AW'(1);
					end
				end
				D_DRAIN: begin
					state_q <= D_UPDATE;
				end
				D_UPDATE: begin
					if (ram_we) begin
						count_q <= count_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign frames   = frames_q;
	assign distinct = DISTINCT_W'(count_q);

endmodule

>>> hdl/can_rx_frame_router_top.sv
// ----------------------------------------------------------------------------
// can_rx_frame_router_top
// Acceptance filter and router for received standard CAN frames.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per frame or table command, mode and frame flags
// in s_tuser. Output stream m_*: exactly one result item per input item, the
// disposition in m_tuser. cfg_wr_en/cfg_wr_data write the diagnostic mode bit;
// the user must use them only while the block is idle; the block does not
// enforce it. One item is handled at a time. Table commands and dropped frames
// go from decode to the finish state and the output register. A routed frame
// walks every slot's ID list in parallel, one list entry per cycle, then
// passes the match mask down the row of slot cells one cell per cycle. A frame
// in diagnostic mode walks the distinct-ID store one entry per cycle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result holds in the block
// until the output register frees up, and no new item is accepted meanwhile.
// Reset disables all slots, clears the diagnostic counters and the mode bit.
// ----------------------------------------------------------------------------
module can_rx_frame_router_top import crfr_pkg::*; #(
	parameter int LISTENER_SLOTS = DEF_LISTENER_SLOTS,
	parameter int IDS_PER_SLOT   = DEF_IDS_PER_SLOT,
	parameter int DIAG_ID_DEPTH  = DEF_DIAG_ID_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// can_id[10:0], dlc[14:11], payload[78:15], slot[81:79],
	// range_low[92:82], range_high[103:93]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0], is_extended[3], is_remote[4]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// listener_mask[7:0], length[11:8], payload_out[75:12],
	// diag_frames[107:76], diag_distinct[113:108], zero[119:114]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// disposition[2:0]
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int AW  = (IDS_PER_SLOT > 1) ? $clog2(IDS_PER_SLOT) : 1;
	localparam int CHW = $clog2(LISTENER_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_DRAIN,
		ST_CHAIN,
		ST_DIAG,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic                    diag_mode_q;
	logic [MODE_W-1:0]       mode_q;
	logic [ID_W-1:0]         id_q;
	logic                    ext_q;
	logic                    rtr_q;
	logic [DLC_W-1:0]        dlc_q;
	logic [DATA_W-1:0]       pay_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [ID_W-1:0]         lo_q;
	logic [ID_W-1:0]         hi_q;
	logic [AW-1:0]           walk_q;
	logic                    rd_en_s1;
	logic [CHW-1:0]          chain_q;
	logic [DISP_W-1:0]       res_disp_q;
	logic [MASK_W-1:0]       res_mask_q;
	logic [LEN_W-1:0]        res_len_q;
	logic [DATA_W-1:0]       res_pay_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic [OUT_USER_W-1:0]   m_tuser_q;

	cell_ctl_t               ctl;
	logic [MASK_W-1:0]       mask_w [LISTENER_SLOTS+1];
	logic                    any_w  [LISTENER_SLOTS+1];
	logic [LISTENER_SLOTS-1:0] append_ok_w;
	logic                    frame_ok;
	logic                    slot_ok;
	logic                    decode;
	logic                    diag_done;
	logic [FRAMES_W-1:0]     diag_frames;
	logic [DISTINCT_W-1:0]   diag_distinct;
	logic [LEN_W-1:0]        clamped_len;

	assign frame_ok    = !ext_q && !rtr_q;
	assign slot_ok     = (32'(slot_q) < LISTENER_SLOTS);
	assign decode      = (state_q == ST_DECODE);
	assign clamped_len = (dlc_q > MAX_DATA_BYTES) ? MAX_DATA_BYTES : dlc_q;

	always_comb begin
		ctl.op_set     = decode && (mode_q == MODE_SET);
		ctl.op_append  = decode && (mode_q == MODE_APPEND);
		ctl.op_disable = decode && (mode_q == MODE_DISABLE);
		ctl.start      = decode && (mode_q == MODE_FRAME) && frame_ok && !diag_mode_q;
		ctl.cmp_en     = rd_en_s1;
		ctl.slot       = slot_q;
		ctl.id         = id_q;
		ctl.lo         = lo_q;
		ctl.hi         = hi_q;
	end

	assign mask_w[0] = '0;
	assign any_w[0]  = 1'b0;

	for (genvar i = 0; i < LISTENER_SLOTS; i++) begin : g_cell
		crfr_cell #(
			.IDX          (i),
			.IDS_PER_SLOT (IDS_PER_SLOT)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.rd_addr   (walk_q),
			.mask_in   (mask_w[i]),
			.any_in    (any_w[i]),
			.mask_out  (mask_w[i+1]),
			.any_out   (any_w[i+1]),
			.append_ok (append_ok_w[i])
		);
	end

	crfr_diag #(
		.DIAG_ID_DEPTH (DIAG_ID_DEPTH)
	) u_diag (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (decode && (mode_q == MODE_CLEAR)),
		.start    (decode && (mode_q == MODE_FRAME) && frame_ok && diag_mode_q),
		.id       (id_q),
		.done     (diag_done),
		.frames   (diag_frames),
		.distinct (diag_distinct)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			diag_mode_q <= 1'b0;
			mode_q      <= '0;
			id_q        <= '0;
			ext_q       <= 1'b0;
			rtr_q       <= 1'b0;
			dlc_q       <= '0;
			pay_q       <= '0;
			slot_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			walk_q      <= '0;
			rd_en_s1    <= 1'b0;
			chain_q     <= '0;
			res_disp_q  <= '0;
			res_mask_q  <= '0;
			res_len_q   <= '0;
			res_pay_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				diag_mode_q <= cfg_wr_data;
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			rd_en_s1 <= (state_q == ST_WALK);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= s_tuser[2:0];
						ext_q   <= s_tuser[3];
						rtr_q   <= s_tuser[4];
						id_q    <= s_tdata[10:0];
						dlc_q   <= s_tdata[14:11];
						pay_q   <= s_tdata[78:15];
						slot_q  <= s_tdata[81:79];
						lo_q    <= s_tdata[92:82];
						hi_q    <= s_tdata[103:93];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_mask_q <= '0;
					res_len_q  <= '0;
					res_pay_q  <= '0;
					res_disp_q <= DISP_REJECT;
					state_q    <= ST_FINISH;
					case (mode_q)
						MODE_FRAME: begin
							if (!frame_ok) begin
								res_disp_q <= DISP_DROPPED;
							end else begin
								res_len_q <= clamped_len;
								res_pay_q <= pay_q;
								if (diag_mode_q) begin
									state_q <= ST_DIAG;
								end else begin
									walk_q  <= '0;
									state_q <= ST_WALK;
								end
							end
						end
						MODE_SET, MODE_DISABLE: begin
							res_disp_q <= slot_ok ? DISP_DONE : DISP_REJECT;
						end
						MODE_APPEND: begin
							res_disp_q <= (slot_ok && (|append_ok_w)) ? DISP_DONE : DISP_REJECT;
						end
						MODE_CLEAR: begin
							res_disp_q <= DISP_DONE;
						end
						default: begin
							res_disp_q <= DISP_REJECT;
						end
					endcase
				end
				ST_WALK: begin
					if (walk_q == AW'(IDS_PER_SLOT - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						walk_q <= walk_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					chain_q <= '0;
					state_q <= ST_CHAIN;
				end
				ST_CHAIN: begin
					if (chain_q == CHW'(LISTENER_SLOTS)) begin
						res_mask_q <= mask_w[LISTENER_SLOTS];
						res_disp_q <= any_w[LISTENER_SLOTS] ? DISP_LISTENERS : DISP_QUEUE;
						state_q    <= ST_FINISH;
					end else begin
						chain_q <= chain_q + CHW'(1);
					end
				end
				ST_DIAG: begin
					if (diag_done) begin
						res_disp_q <= DISP_DIAG;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {OUT_PAD_W'(0), diag_distinct, diag_frames,
							res_pay_q, res_len_q, res_mask_q};
						m_tuser_q  <= res_disp_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
